@@ hdl/picf_pkg.sv @@
// Package: shared types and constants for the pulse interval capture FIFO.
package picf_pkg;

    localparam int STAMP_W        = 32;
    localparam int FILL_W         = 9;
    localparam int RING_DEPTH_DEF = 512;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_PULSE = 1'b0,
        CMD_POP   = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_DEAD     = 3'd1,
        ST_OVERRUN  = 3'd2,
        ST_INTERVAL = 3'd3,
        ST_FIRST    = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t               command;
        logic [STAMP_W-1:0] timestamp;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [STAMP_W-1:0] interval;
        logic [STAMP_W-1:0] overrun_count;
        logic [FILL_W-1:0]  fill_level;
    } out_item_t;

    // Front-end classification of one item, handed to the back end
    typedef struct packed {
        logic               pop_hit;
        status_t            status;
        logic [STAMP_W-1:0] overrun;
        logic [FILL_W-1:0]  fill;
    } fe_beat_t;

    typedef struct packed {
        fe_beat_t           meta;
        logic [STAMP_W-1:0] stamp;
    } q_entry_t;

endpackage

@@ hdl/picf_front.sv @@
// Front end: accepts beats, applies dead time, owns the timestamp ring.
module picf_front
    import picf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [STAMP_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               push_valid,
    input  logic               push_ready,
    output q_entry_t           push_data
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    // ring storage, no reset
    logic [STAMP_W-1:0] ring [0:RING_DEPTH-1];
    logic [STAMP_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   cnt_reg, cnt_next;
    logic [STAMP_W-1:0] dropped_reg, dropped_next;
    logic [STAMP_W-1:0] last_time_reg, last_time_next;
    logic [STAMP_W-1:0] min_gap_reg;
    logic               s1_valid_reg, s1_valid_next;
    fe_beat_t           s1_meta_reg, s1_meta_next;

    logic               accept;
    logic               push;
    logic               ram_we;
    logic               ram_re;
    logic [STAMP_W-1:0] gap;
    logic               dead;
    logic               full;
    logic               empty;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_inc;
    logic [FILL_W+PTR_W-1:0] fill_wide;

    // handshake: stage register drains into the queue
    assign push       = s1_valid_reg && push_ready;
    assign in_ready   = !s1_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = s1_valid_reg;
    assign push_data  = '{meta: s1_meta_reg, stamp: rd_data_reg};

    // classification terms
    assign gap        = in_data.timestamp - last_time_reg;
    assign dead       = gap < min_gap_reg;
    assign full       = cnt_reg == PTR_LAST;
    assign empty      = cnt_reg == '0;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign fill_wide  = {{FILL_W{1'b0}}, cnt_next};

    // next-state for ring control
    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        cnt_next       = cnt_reg;
        dropped_next   = dropped_reg;
        last_time_next = last_time_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        s1_meta_next   = s1_meta_reg;
        s1_meta_next.pop_hit = 1'b0;
        s1_meta_next.status  = ST_EMPTY;
        if (accept)
        begin
            unique case (in_data.command)
                CMD_PULSE:
                begin
                    if (dead)
                    begin
                        s1_meta_next.status = ST_DEAD;
                    end
                    else
                    begin
                        last_time_next = in_data.timestamp;
                        if (full)
                        begin
                            dropped_next        = dropped_reg + 1'b1;
                            s1_meta_next.status = ST_OVERRUN;
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            wr_ptr_next         = wr_ptr_inc;
                            cnt_next            = cnt_reg + 1'b1;
                            s1_meta_next.status = ST_STORED;
                        end
                    end
                end
                CMD_POP:
                begin
                    if (empty)
                    begin
                        s1_meta_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re                = 1'b1;
                        rd_ptr_next           = rd_ptr_inc;
                        cnt_next              = cnt_reg - 1'b1;
                        s1_meta_next.pop_hit  = 1'b1;
                        s1_meta_next.status   = ST_FIRST;
                    end
                end
                default:
                begin
                    s1_meta_next.status = ST_EMPTY;
                end
            endcase
        end
        s1_meta_next.overrun = dropped_next;
        s1_meta_next.fill    = fill_wide[FILL_W-1:0];
    end

    // stage valid
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (push)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            dropped_reg   <= '0;
            last_time_reg <= '0;
            min_gap_reg   <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            dropped_reg   <= dropped_next;
            last_time_reg <= last_time_next;
            s1_valid_reg  <= s1_valid_next;
            if (cfg_wr_en)
                min_gap_reg <= cfg_wr_data;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_meta_reg <= s1_meta_next;
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ram_we)
            ring[wr_ptr_reg] <= in_data.timestamp;
        if (ram_re)
            rd_data_reg <= ring[rd_ptr_reg];
    end

endmodule

@@ hdl/picf_queue.sv @@
// Short queue between front end and back end.
module picf_queue
    import picf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_data
);

    q_entry_t           entry_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign push_ready = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hdl/picf_back.sv @@
// Back end: turns popped timestamps into intervals, holds the output register.
module picf_back
    import picf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  q_entry_t  q_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;
    logic [STAMP_W-1:0] prev_time_reg, prev_time_next;
    logic               have_prev_reg, have_prev_next;
    logic               take;

    assign q_ready   = !out_valid_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // result assembly
    always_comb
    begin
        prev_time_next              = prev_time_reg;
        have_prev_next              = have_prev_reg;
        out_data_next.status        = q_data.meta.status;
        out_data_next.interval      = '0;
        out_data_next.overrun_count = q_data.meta.overrun;
        out_data_next.fill_level    = q_data.meta.fill;
        if (q_data.meta.pop_hit)
        begin
            if (have_prev_reg)
            begin
                out_data_next.status   = ST_INTERVAL;
                out_data_next.interval = q_data.stamp - prev_time_reg;
            end
            else
            begin
                out_data_next.status = ST_FIRST;
            end
            prev_time_next = q_data.stamp;
            have_prev_next = 1'b1;
        end
    end

    // output beat valid
    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_time_reg <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                prev_time_reg <= prev_time_next;
                have_prev_reg <= have_prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= out_data_next;
    end

endmodule

@@ hdl/pulse_interval_capture_fifo.sv @@
// An accepted beat passes the front stage, queue and back-end output register.
// Throughput: one beat per cycle unless stalled; a beat uses at most one entry of
// the single-write, registered-read ring port; results drain at out_ready's pace.
// Reset (rst_n, async, active low) clears pointers, counters, dead time and
// the last/previous times; ring contents are not cleared and need no sweep.
// Top level: pulse interval capture FIFO.
module pulse_interval_capture_fifo
    import picf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [STAMP_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data
);

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_data;
    logic     q_valid;
    logic     q_ready;
    q_entry_t q_data;

    picf_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    picf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    picf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ hdl/picf_checker.sv @@
// Checker: port-level assertions for the pulse interval capture FIFO, with bind.
module picf_checker
    import picf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input in_item_t           in_data,
    input logic               out_valid,
    input logic               out_ready,
    input out_item_t          out_data
);

    localparam int FULL_WIDE = RING_DEPTH - 1;
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(FULL_WIDE % (1 << FILL_W));

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // only an interval result carries a nonzero interval
    a_interval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_INTERVAL |-> out_data.interval == '0)
        else $error("interval set on a non-interval result");

    // empty pop reports an empty ring
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_EMPTY |-> out_data.fill_level == '0)
        else $error("empty status with nonzero fill level");

    // overrun only when the ring is at capacity
    a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OVERRUN |-> out_data.fill_level == FULL_FILL)
        else $error("overrun reported with ring not full");

endmodule

bind pulse_interval_capture_fifo picf_checker #(.RING_DEPTH(RING_DEPTH)) u_picf_checker (.*);

@@ bench/testbench.sv @@
// Testbench for the pulse interval capture FIFO: random and directed beats against a predictor.
`timescale 1ns / 100ps

module testbench;
    import picf_pkg::*;

    localparam int RING_SLOTS = RING_DEPTH_DEF - 1;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_CAP = 40;

    // Predicts result beats from accepted pulse/pop beats and checks DUT output
    class interval_scoreboard;
        logic [STAMP_W-1:0] held_stamps[$];
        out_item_t          expected_beats[$];
        logic [STAMP_W-1:0] dead_time;
        logic [STAMP_W-1:0] last_kept;
        logic [STAMP_W-1:0] prev_popped;
        logic               have_prev;
        logic [STAMP_W-1:0] drops;
        int                 mismatches;

        function new();
            dead_time   = '0;
            last_kept   = '0;
            prev_popped = '0;
            have_prev   = 1'b0;
            drops       = '0;
            mismatches  = 0;
        endfunction

        task report(string msg);
            if (mismatches < PRINT_CAP)
                $display("mismatch @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Work out the result of one accepted input beat
        function void note_input(in_item_t beat);
            out_item_t          res;
            logic [STAMP_W-1:0] since_last;
            logic [STAMP_W-1:0] oldest;
            res = '0;
            if (beat.command == CMD_PULSE) begin
                since_last = beat.timestamp - last_kept;
                if (since_last < dead_time) begin
                    res.status = ST_DEAD;
                end
                else begin
                    last_kept = beat.timestamp;
                    if (held_stamps.size() == RING_SLOTS) begin
                        drops++;
                        res.status = ST_OVERRUN;
                    end
                    else begin
                        held_stamps.push_back(beat.timestamp);
                        res.status = ST_STORED;
                    end
                end
            end
            else begin
                if (held_stamps.size() == 0) begin
                    res.status = ST_EMPTY;
                end
                else begin
                    oldest = held_stamps.pop_front();
                    if (have_prev) begin
                        res.interval = oldest - prev_popped;
                        res.status   = ST_INTERVAL;
                    end
                    else begin
                        res.status = ST_FIRST;
                    end
                    prev_popped = oldest;
                    have_prev   = 1'b1;
                end
            end
            res.overrun_count = drops;
            res.fill_level    = FILL_W'(held_stamps.size());
            expected_beats.push_back(res);
        endfunction

        // Compare one result beat with the oldest prediction
        task check_result(out_item_t got);
            out_item_t want;
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected result beat %h", got));
            end
            else begin
                want = expected_beats.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.interval !== want.interval)
                    report($sformatf("interval %h, want %h", got.interval, want.interval));
                if (got.overrun_count !== want.overrun_count)
                    report($sformatf("overrun_count %h, want %h",
                                     got.overrun_count, want.overrun_count));
                if (got.fill_level !== want.fill_level)
                    report($sformatf("fill_level %0d, want %0d",
                                     got.fill_level, want.fill_level));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [STAMP_W-1:0] cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;

    interval_scoreboard sb;
    bit                 idle_on;
    int                 cycle_count;
    int                 stall_left;

    pulse_interval_capture_fifo i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver backpressure in random bursts
    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // Drive one beat at the falling edge, return at the falling edge after acceptance
    task send_beat(in_item_t beat);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(beat);
        @(negedge clk);
    endtask

    task pulse(logic [STAMP_W-1:0] stamp);
        in_item_t beat;
        beat.command   = CMD_PULSE;
        beat.timestamp = stamp;
        send_beat(beat);
    endtask

    task pop();
        in_item_t beat;
        beat.command   = CMD_POP;
        beat.timestamp = $urandom;
        send_beat(beat);
    endtask

    // Stop sending and wait until every result is back
    task settle();
        in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Dead-time write, only while idle
    task write_dead_time(logic [STAMP_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.dead_time = value;
    endtask

    // Random mix aimed around the dead-time edge of the last kept pulse
    task random_phase(int count, int pop_pct);
        logic [STAMP_W-1:0] delta;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < pop_pct) begin
                pop();
            end
            else begin
                case ($urandom_range(0, 9))
                    0: delta = $urandom;
                    1: delta = sb.dead_time - 1;
                    2: delta = sb.dead_time;
                    3: delta = (sb.dead_time == 0) ? '0 : $urandom_range(0, sb.dead_time - 1);
                    default: delta = sb.dead_time + $urandom_range(0, 300);
                endcase
                if ($urandom_range(0, 19) == 0)
                    pulse($urandom);
                else
                    pulse(sb.last_kept + delta);
            end
        end
    endtask

    initial
    begin
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        idle_on     = 1'b1;
        cycle_count = 0;
        stall_left  = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Dead time before any pulse: early pulses fall inside it
        write_dead_time(32'd1000);
        pop();
        pulse(32'd5);
        pulse(32'd999);
        pulse(32'd1000);
        pulse(32'hFFFF_FFFF);
        pulse(32'd743);
        pulse(32'd2000);
        pop();
        pop();
        pop();
        pop();
        settle();

        // Zero dead time: nothing rejected, repeated and opposite stamps
        write_dead_time('0);
        pulse(32'd0);
        pulse(32'd0);
        pulse(32'h8000_0000);
        pulse(32'h7FFF_FFFF);
        pop();
        pop();
        pop();
        pop();
        pop();
        settle();

        // Random phases across dead-time settings, extremes included
        write_dead_time('0);
        random_phase(140, 50);
        settle();
        write_dead_time($urandom_range(1, 200));
        random_phase(140, 40);
        settle();
        write_dead_time(32'hFFFF_FFFF);
        random_phase(140, 50);
        settle();
        write_dead_time($urandom);
        random_phase(140, 50);
        settle();
        write_dead_time(32'd1);
        random_phase(140, 30);
        settle();

        // Last part, no idling: fill the ring, overrun it, then mix
        idle_on = 1'b0;
        write_dead_time('0);
        while (sb.held_stamps.size() < RING_SLOTS)
            pulse($urandom);
        repeat (4) pulse($urandom);
        repeat (20) pop();
        random_phase(40, 50);
        settle();

        repeat (10) @(posedge clk);
        if (sb.expected_beats.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_beats.size()));
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/picf_pkg.sv
hdl/picf_front.sv
hdl/picf_queue.sv
hdl/picf_back.sv
hdl/pulse_interval_capture_fifo.sv
hdl/picf_checker.sv
bench/testbench.sv
